// ----- rtl/dpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dpd_pkg;

  // Default sizing handed to the top level
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned MAX_PLANES_DEF  = 4;

  // Fixed field widths
  localparam int unsigned THR_W     = 15;
  localparam int unsigned PLANE_W   = 2;
  localparam int unsigned NUM_THR   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_PLANE0 = 3'd0,
    CFG_THR_PLANE1 = 3'd1,
    CFG_THR_PLANE2 = 3'd2,
    CFG_THR_PLANE3 = 3'd3,
    CFG_BLUR_MODE  = 3'd4,
    CFG_COUPLED    = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- rtl/dpd_decide.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Four-tap average and threshold decision for one sample group
module dpd_decide
  import dpd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic [SAMPLE_BITS-1:0] center_i,
  input  wire logic [SAMPLE_BITS-1:0] ref_a_i,
  input  wire logic [SAMPLE_BITS-1:0] ref_b_i,
  input  wire logic [SAMPLE_BITS-1:0] ref_c_i,
  input  wire logic [SAMPLE_BITS-1:0] ref_d_i,
  input  wire logic [THR_W-1:0]       thr_i,
  input  wire logic                   blur_i,
  output logic      [SAMPLE_BITS-1:0] avg_o,
  output logic                        pass_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + 2;
  localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] d_avg, d_a, d_b, d_c, d_d;
  logic                   lt_avg, lt_a, lt_b, lt_c, lt_d;

  function automatic logic [SAMPLE_BITS-1:0] abs_diff(
    input logic [SAMPLE_BITS-1:0] x,
    input logic [SAMPLE_BITS-1:0] y
  );
    return (x > y) ? (x - y) : (y - x);
  endfunction

  // floor of the mean of the four references
  assign sum   = SUM_W'(ref_a_i) + SUM_W'(ref_b_i) + SUM_W'(ref_c_i) + SUM_W'(ref_d_i);
  assign avg_o = sum[SUM_W-1:2];

  assign d_avg = abs_diff(center_i, avg_o);
  assign d_a   = abs_diff(center_i, ref_a_i);
  assign d_b   = abs_diff(center_i, ref_b_i);
  assign d_c   = abs_diff(center_i, ref_c_i);
  assign d_d   = abs_diff(center_i, ref_d_i);

  assign lt_avg = CMP_W'(d_avg) < CMP_W'(thr_i);
  assign lt_a   = CMP_W'(d_a) < CMP_W'(thr_i);
  assign lt_b   = CMP_W'(d_b) < CMP_W'(thr_i);
  assign lt_c   = CMP_W'(d_c) < CMP_W'(thr_i);
  assign lt_d   = CMP_W'(d_d) < CMP_W'(thr_i);

  // blur compares to the average, otherwise every reference must be close
  assign pass_o = blur_i ? lt_avg : (lt_a & lt_b & lt_c & lt_d);

endmodule

`default_nettype wire

// ----- rtl/deband_pixel_decision.sv -----
// An input transfer reaches its result through the input register and then the result register.
// Throughput: one item per cycle when planes decide on their own and the result stream accepts.
// Coupled pixels: from the cycle after the last plane leaves the input register, n results drain
// from the held-plane registers, one per cycle while the result stream accepts them;
// the input register waits while they drain.
// Reset (asynchronous, active low): nothing held or pending, thresholds 5, blur on, coupled off.
`timescale 1ns / 1ps
`default_nettype none

module deband_pixel_decision
  import dpd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned MAX_PLANES  = MAX_PLANES_DEF,
  localparam int unsigned IN_DATA_W  = ((5 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // center_sample, ref_a, ref_b, ref_c, ref_d (low to high), zero padded
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // plane
  input  wire logic [PLANE_W-1:0]    s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_value, zero padded
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // out_plane
  output logic      [PLANE_W-1:0]    m_axis_tuser,
  output logic                       m_axis_tlast,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [THR_W-1:0]      cfg_data_i
);

  localparam int unsigned SW    = SAMPLE_BITS;
  localparam int unsigned IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam logic [IDX_W-1:0] TOP_SLOT = IDX_W'(MAX_PLANES - 1);

  // configuration registers
  logic [THR_W-1:0] thr_q [NUM_THR];
  logic             blur_q, coupled_q;

  // input register
  logic               in_vld_q;
  logic [PLANE_W-1:0] in_plane_q;
  logic [SW-1:0]      in_center_q, in_a_q, in_b_q, in_c_q, in_d_q;
  logic               in_last_q;

  // held planes of a coupled pixel
  logic [SW-1:0]    held_center_q [MAX_PLANES];
  logic [SW-1:0]    held_avg_q    [MAX_PLANES];
  logic [IDX_W-1:0] planes_held_q;
  logic             pass_acc_q;

  // drain of a released pixel
  logic             drain_q;
  logic [IDX_W-1:0] drain_idx_q, drain_top_q;
  logic             all_q;

  // result register
  logic               out_vld_q;
  logic [PLANE_W-1:0] out_plane_q;
  logic [SW-1:0]      out_value_q;
  logic               out_last_q;

  logic [SW-1:0] avg;
  logic          pass;
  logic          out_free, in_fire, release_px, all_now, drain_emit;

  // decision on the registered item
  dpd_decide #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_decide (
    .center_i (in_center_q),
    .ref_a_i  (in_a_q),
    .ref_b_i  (in_b_q),
    .ref_c_i  (in_c_q),
    .ref_d_i  (in_d_q),
    .thr_i    (thr_q[in_plane_q]),
    .blur_i   (blur_q),
    .avg_o    (avg),
    .pass_o   (pass)
  );

  // handshake and control decode
  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_fire       = in_vld_q && !drain_q && (coupled_q || out_free);
  assign s_axis_tready = !in_vld_q || in_fire;
  assign release_px    = in_last_q || (planes_held_q == TOP_SLOT);
  assign all_now       = (planes_held_q == '0) ? pass : (pass_acc_q & pass);
  assign drain_emit    = drain_q && out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THR; i++) thr_q[i] <= THR_RESET;
      blur_q    <= 1'b1;
      coupled_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_THR_PLANE0: thr_q[0] <= cfg_data_i;
        CFG_THR_PLANE1: thr_q[1] <= cfg_data_i;
        CFG_THR_PLANE2: thr_q[2] <= cfg_data_i;
        CFG_THR_PLANE3: thr_q[3] <= cfg_data_i;
        CFG_BLUR_MODE:  blur_q    <= cfg_data_i[0];
        CFG_COUPLED:    coupled_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_plane_q  <= s_axis_tuser;
      in_center_q <= s_axis_tdata[0*SW +: SW];
      in_a_q      <= s_axis_tdata[1*SW +: SW];
      in_b_q      <= s_axis_tdata[2*SW +: SW];
      in_c_q      <= s_axis_tdata[3*SW +: SW];
      in_d_q      <= s_axis_tdata[4*SW +: SW];
      in_last_q   <= s_axis_tlast;
    end
  end

  // held plane store, written at the fill slot
  always_ff @(posedge clk_i) begin
    if (in_fire && coupled_q) begin
      held_center_q[planes_held_q] <= in_center_q;
      held_avg_q[planes_held_q]    <= avg;
    end
  end

  // coupled fill count, running pass flag and drain sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_held_q <= '0;
      pass_acc_q    <= 1'b0;
      drain_q       <= 1'b0;
      drain_idx_q   <= '0;
      drain_top_q   <= '0;
      all_q         <= 1'b0;
    end else begin
      if (in_fire && coupled_q) begin
        if (release_px) begin
          planes_held_q <= '0;
          drain_q       <= 1'b1;
          drain_idx_q   <= '0;
          drain_top_q   <= planes_held_q;
          all_q         <= all_now;
        end else begin
          planes_held_q <= planes_held_q + 1'b1;
          pass_acc_q    <= all_now;
        end
      end else if (drain_emit) begin
        if (drain_idx_q == drain_top_q) begin
          drain_q <= 1'b0;
        end else begin
          drain_idx_q <= drain_idx_q + 1'b1;
        end
      end
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= drain_q || (in_fire && !coupled_q);
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (drain_emit) begin
      out_plane_q <= PLANE_W'(drain_idx_q);
      out_value_q <= all_q ? held_avg_q[drain_idx_q] : held_center_q[drain_idx_q];
      out_last_q  <= (drain_idx_q == drain_top_q);
    end else if (in_fire && !coupled_q) begin
      out_plane_q <= in_plane_q;
      out_value_q <= pass ? avg : in_center_q;
      out_last_q  <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_value_q);
  assign m_axis_tuser  = out_plane_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/dpd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the result stream
module dpd_checker
  import dpd_pkg::*;
#(
  parameter int unsigned OUT_DATA_W = 16
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [PLANE_W-1:0]    m_axis_tuser,
  input wire logic                  m_axis_tlast
);

  // a result offered is not withdrawn before its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before transfer");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // no result is pending right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind deband_pixel_decision dpd_checker #(
  .OUT_DATA_W (OUT_DATA_W)
) u_dpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
